// File: hdl/pwpr_pkg.sv
// Shared types and constants of the PID term tracker with periodic restart.
// Used by pwpr_mac, pwpr_div and pid_with_periodic_restart_core; no dependencies.
package pwpr_pkg;

	localparam int TERM_W = 32;
	localparam int GAIN_W = 16;
	localparam int PROD_W = TERM_W + GAIN_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int DIV_W  = 16;
	localparam int CNT_W  = 16;
	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_GAIN_P  = 3'd0;
	localparam logic [2:0] REG_GAIN_I  = 3'd1;
	localparam logic [2:0] REG_GAIN_D  = 3'd2;
	localparam logic [2:0] REG_DIVISOR = 3'd3;
	localparam logic [2:0] REG_PERIOD  = 3'd4;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DONE
	} pwpr_state_t;

	typedef struct packed {
		logic clear;
		logic acc_en;
	} pwpr_mac_ctrl_t;

	// Clamp a 33-bit signed sum into the 32-bit signed range.
	function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [TERM_W:0] v);
		logic signed [TERM_W-1:0] r;
		begin
			if (v[TERM_W] != v[TERM_W-1]) begin
				r = v[TERM_W] ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
			end else begin
				r = v[TERM_W-1:0];
			end
			return r;
		end
	endfunction

endpackage

// File: hdl/pwpr_mac.sv
// Shared multiply-accumulate unit: one 32x16 signed product per cycle.
// Depends on pwpr_pkg.
module pwpr_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  pwpr_pkg::pwpr_mac_ctrl_t                ctrl,
	input  logic signed [pwpr_pkg::TERM_W-1:0]      term,
	input  logic signed [pwpr_pkg::GAIN_W-1:0]      gain,
	output logic signed [pwpr_pkg::SUM_W-1:0]       acc
);
	import pwpr_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]  acc_q;

	// Register the product before it enters the adder.
	always_ff @(posedge clk) begin
		prod_s1 <= term * gain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + SUM_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

// File: hdl/pwpr_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on pwpr_pkg.
module pwpr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pwpr_pkg::SUM_W-1:0]    numer,
	input  logic [pwpr_pkg::DIV_W-1:0]    denom,
	output logic [pwpr_pkg::SUM_W-1:0]    quot,
	output logic                          done
);
	import pwpr_pkg::*;

	localparam int ITER   = SUM_W / 2;
	localparam int ITER_W = $clog2(ITER);

	logic [SUM_W-1:0]  num_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  den_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SUM_W-1:0]  num_nxt;
	logic [DIV_W-1:0]  rem_nxt;
	logic [DIV_W:0]    trial;

	// Two restoring steps: shift in a numerator bit, subtract when it fits.
	always_comb begin
		num_nxt = num_q;
		rem_nxt = rem_q;
		trial   = '0;
		for (int k = 0; k < 2; k++) begin
			trial   = {rem_nxt, num_nxt[SUM_W-1]};
			num_nxt = {num_nxt[SUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_nxt    = DIV_W'(trial - {1'b0, den_q});
				num_nxt[0] = 1'b1;
			end else begin
				rem_nxt = trial[DIV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			num_q <= num_nxt;
			rem_q <= rem_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == ITER_W'(ITER - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == ITER_W'(ITER - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign quot = num_q;
	assign done = done_q;

endmodule

// File: hdl/pid_with_periodic_restart_core.sv
// PID term tracker with periodic restart: top level with sequencer and register file.
// Depends on pwpr_pkg, pwpr_mac and pwpr_div.
//
// Usage:
//   Input channel (in_valid/in_stall, opcode, error_value): opcode OP_UPDATE folds
//   error_value into the proportional, integral and derivative terms and counts the
//   update; when the count reaches restart_period all terms and the count clear.
//   Opcode OP_CLEAR clears them directly. Every beat yields one result beat.
//   Output channel (out_valid/out_stall, drive, restarted): drive is the weighted
//   sum P*gp + I*gi + D*gd divided by divisor, rounded half away from zero and
//   clamped to 32-bit signed; restarted flags an item that cleared the terms.
//   Flow: an accepted item goes through the shared multiplier-accumulator, a load
//   state, the 2-bit-per-cycle divider until its done flag for the 50-bit quotient,
//   and a finish state. in_stall is high from the accept until the return to idle,
//   so one item is in flight at a time and no new beat is taken before the last
//   item is through. A finished result sits in the output register; a stalled
//   output holds it, and the next item waits in the finish state until that
//   register frees up. Reset clears the terms, count and gains, sets divisor to 1
//   and the period to 16. The user must write registers over the APB port only
//   while the block is idle; the block itself does not enforce this.
module pid_with_periodic_restart_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   opcode,
	input  logic signed [pwpr_pkg::TERM_W-1:0]     error_value,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [pwpr_pkg::TERM_W-1:0]     drive,
	output logic                                   restarted,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [pwpr_pkg::ADDR_W-1:0]            paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);
	import pwpr_pkg::*;

	// Configuration registers
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [DIV_W-1:0]         divisor_q;
	logic [CNT_W-1:0]         period_q;

	// Term state
	logic signed [TERM_W-1:0] term_p_q, term_i_q, term_d_q;
	logic [CNT_W-1:0]         count_q;
	logic                     restart_q;

	// Sequencer
	pwpr_state_t              state_q, state_nxt;
	logic [1:0]               step_q;
	logic                     neg_q;

	// Output register
	logic                     out_valid_q;
	logic signed [TERM_W-1:0] drive_q;
	logic                     restarted_q;

	logic                     in_fire;
	logic                     cfg_wr;
	logic [2:0]               cfg_idx;
	logic [CNT_W-1:0]         count_inc;
	logic signed [TERM_W-1:0] new_d, new_i;

	pwpr_mac_ctrl_t           mac_ctrl;
	logic signed [TERM_W-1:0] mac_term;
	logic signed [GAIN_W-1:0] mac_gain;
	logic signed [SUM_W-1:0]  acc;

	logic [DIV_W-1:0]         div_eff;
	logic [SUM_W-1:0]         acc_mag;
	logic [SUM_W-1:0]         numer;
	logic                     div_start;
	logic [SUM_W-1:0]         quot;
	logic                     div_done;
	logic                     out_free;
	logic                     out_load;
	logic signed [TERM_W-1:0] drive_nxt;

	assign in_fire = in_valid && !in_stall;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];
	assign pready  = 1'b1;

	// ---------------------------------------------------------------
	// Register file
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			divisor_q <= DIV_W'(1);
			period_q  <= CNT_W'(16);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_GAIN_P:  gain_p_q  <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:  gain_i_q  <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:  gain_d_q  <= pwdata[GAIN_W-1:0];
				REG_DIVISOR: divisor_q <= pwdata[DIV_W-1:0];
				REG_PERIOD:  period_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_GAIN_P:  prdata = {{(32-GAIN_W){1'b0}}, gain_p_q};
			REG_GAIN_I:  prdata = {{(32-GAIN_W){1'b0}}, gain_i_q};
			REG_GAIN_D:  prdata = {{(32-GAIN_W){1'b0}}, gain_d_q};
			REG_DIVISOR: prdata = {{(32-DIV_W){1'b0}}, divisor_q};
			REG_PERIOD:  prdata = {{(32-CNT_W){1'b0}}, period_q};
			default:     prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Term update at the accepted beat
	// ---------------------------------------------------------------
	assign count_inc = count_q + 1'b1;
	assign new_d     = sat_term({error_value[TERM_W-1], error_value}
		- {term_p_q[TERM_W-1], term_p_q});
	assign new_i     = sat_term({error_value[TERM_W-1], error_value}
		+ {term_i_q[TERM_W-1], term_i_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_p_q  <= '0;
			term_i_q  <= '0;
			term_d_q  <= '0;
			count_q   <= '0;
			restart_q <= 1'b0;
		end else if (in_fire) begin
			// Clear on a clear beat or when the update count reaches the period.
			if (opcode == OP_CLEAR || count_inc >= period_q) begin
				term_p_q  <= '0;
				term_i_q  <= '0;
				term_d_q  <= '0;
				count_q   <= '0;
				restart_q <= 1'b1;
			end else begin
				term_p_q  <= error_value;
				term_i_q  <= new_i;
				term_d_q  <= new_d;
				count_q   <= count_inc;
				restart_q <= 1'b0;
			end
		end else if (cfg_wr && cfg_idx == REG_PERIOD) begin
			// A new period restarts the count.
			count_q <= '0;
		end
	end

	// ---------------------------------------------------------------
	// Shared multiply-accumulate: step 0..2 feed P, I, D; steps 1..3 add.
	// ---------------------------------------------------------------
	always_comb begin
		unique case (step_q)
			2'd0:    begin mac_term = term_p_q; mac_gain = gain_p_q; end
			2'd1:    begin mac_term = term_i_q; mac_gain = gain_i_q; end
			default: begin mac_term = term_d_q; mac_gain = gain_d_q; end
		endcase
	end

	assign mac_ctrl.clear  = in_fire;
	assign mac_ctrl.acc_en = (state_q == ST_MAC) && (step_q != 2'd0);

	pwpr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.term   (mac_term),
		.gain   (mac_gain),
		.acc    (acc)
	);

	// ---------------------------------------------------------------
	// Rounded division on the magnitude; sign restored at the finish.
	// ---------------------------------------------------------------
	assign div_eff   = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
	assign acc_mag   = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
	assign numer     = acc_mag + SUM_W'(div_eff >> 1);
	assign div_start = (state_q == ST_DIV_LOAD);

	pwpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numer),
		.denom  (div_eff),
		.quot   (quot),
		.done   (div_done)
	);

	// Clamp the signed quotient to 32 bits.
	always_comb begin
		if (neg_q) begin
			if (quot > SUM_W'(64'h8000_0000)) begin
				drive_nxt = {1'b1, {(TERM_W-1){1'b0}}};
			end else begin
				drive_nxt = -quot[TERM_W-1:0];
			end
		end else begin
			if (quot > SUM_W'(64'h7FFF_FFFF)) begin
				drive_nxt = {1'b0, {(TERM_W-1){1'b1}}};
			end else begin
				drive_nxt = quot[TERM_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_MAC) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (div_start) begin
				neg_q <= acc[SUM_W-1];
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = ST_MAC;
				end
			end
			ST_MAC: begin
				if (step_q == 2'd3) begin
					state_nxt = ST_DIV_LOAD;
				end
			end
			ST_DIV_LOAD: begin
				state_nxt = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (div_done) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hold until the output register can take the result.
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_q     <= drive_nxt;
			restarted_q <= restart_q;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign restarted = restarted_q;

endmodule

// File: tb/pwpr_checker.sv
`timescale 1ns / 1ps
// Drive checker for pid_with_periodic_restart_core: follows APB writes and
// both beat channels, predicts each drive beat and compares. Depends on pwpr_pkg.
module pwpr_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic                                   opcode,
	input  logic signed [pwpr_pkg::TERM_W-1:0]     error_value,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic signed [pwpr_pkg::TERM_W-1:0]     drive,
	input  logic                                   restarted,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic                                   pready,
	input  logic [pwpr_pkg::ADDR_W-1:0]            paddr,
	input  logic [31:0]                            pwdata,
	output int                                     fail_count,
	output int                                     pending
);
	import pwpr_pkg::*;

	typedef struct packed {
		logic signed [TERM_W-1:0] drive;
		logic                     restarted;
	} drive_beat_t;

	drive_beat_t drive_q[$];
	drive_beat_t want;
	int n_fail;

	logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
	logic [DIV_W-1:0] div_reg;
	logic [CNT_W-1:0] period_reg, upd_cnt;
	longint prop_t, integ_t, deriv_t;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic void clear_terms();
		prop_t = 0;
		integ_t = 0;
		deriv_t = 0;
		upd_cnt = '0;
	endfunction

	// Fold one item into the terms and return the drive beat it yields.
	function automatic drive_beat_t predict_drive(input logic op,
			input logic signed [TERM_W-1:0] e);
		drive_beat_t r;
		longint sum, b, q;
		r.restarted = 1'b0;
		if (op == OP_CLEAR) begin
			clear_terms();
			r.restarted = 1'b1;
		end else begin
			deriv_t = clamp32(longint'(e) - prop_t);
			integ_t = clamp32(longint'(e) + integ_t);
			prop_t = longint'(e);
			upd_cnt = upd_cnt + 1'b1;
			if (upd_cnt >= period_reg) begin
				clear_terms();
				r.restarted = 1'b1;
			end
		end
		sum = prop_t * longint'(gain_p) + integ_t * longint'(gain_i)
			+ deriv_t * longint'(gain_d);
		b = div_reg;
		if (b == 0)
			b = 1;
		// round half away from zero, then truncate
		if (sum < 0)
			q = (sum - b / 2) / b;
		else
			q = (sum + b / 2) / b;
		r.drive = TERM_W'(clamp32(q));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q.delete();
			gain_p = '0;
			gain_i = '0;
			gain_d = '0;
			div_reg = 16'd1;
			period_reg = 16'd16;
			clear_terms();
			n_fail = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drive_q.size() == 0) begin
					$error("drive beat with nothing expected: drive %0d restarted %0b",
						drive, restarted);
					n_fail++;
				end else begin
					want = drive_q.pop_front();
					if (drive !== want.drive) begin
						$error("drive mismatch: expected %0d, actual %0d", want.drive, drive);
						n_fail++;
					end
					if (restarted !== want.restarted) begin
						$error("restarted mismatch: expected %0b, actual %0b",
							want.restarted, restarted);
						n_fail++;
					end
				end
			end
			if (in_valid && !in_stall)
				drive_q.push_back(predict_drive(opcode, error_value));
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_GAIN_P:  gain_p = pwdata[15:0];
					REG_GAIN_I:  gain_i = pwdata[15:0];
					REG_GAIN_D:  gain_d = pwdata[15:0];
					REG_DIVISOR: div_reg = pwdata[15:0];
					REG_PERIOD: begin
						period_reg = pwdata[15:0];
						upd_cnt = '0;
					end
					default: ;
				endcase
			end
			fail_count <= n_fail;
			pending <= drive_q.size();
		end
	end

endmodule

// File: tb/tb_pid_with_periodic_restart_core.sv
`timescale 1ns / 1ps
// Top of the testbench for pid_with_periodic_restart_core: clock, reset, APB setup,
// directed and random error beats, output stalls and the verdict. Uses pwpr_checker.
module tb_pid_with_periodic_restart_core;
	import pwpr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel
	localparam int SETTLE_CYCLES  = 40;    // a bit over one item's latency
	localparam int PHASE_ITEMS    = 255;
	localparam int PHASES         = 6;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid, in_stall, opcode;
	logic signed [TERM_W-1:0] error_value;
	logic                     out_valid, out_stall, restarted;
	logic signed [TERM_W-1:0] drive;
	logic                     psel, penable, pwrite, pready;
	logic [ADDR_W-1:0]        paddr;
	logic [31:0]              pwdata, prdata;

	int fail_count, pending;
	int gap_pct, stall_pct;   // idle-burst odds in percent (gap_pct per offered beat)
	int quiet_cycles;

	pid_with_periodic_restart_core u_top (
		.clk, .arst_n,
		.in_valid, .in_stall, .opcode, .error_value,
		.out_valid, .out_stall, .drive, .restarted,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	pwpr_checker u_checker (
		.clk, .arst_n,
		.in_valid, .in_stall, .opcode, .error_value,
		.out_valid, .out_stall, .drive, .restarted,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Abort when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("pid_with_periodic_restart_core test failed");
				$finish;
			end
		end
	end

	// Output side: throw in stall bursts at the phase's rate.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Setup cycle, then access cycle; the register takes the data at the edge
	// where penable and pready are both high.
	task automatic apb_write(input logic [2:0] idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one beat, maybe after an idle burst; return at the edge that takes it.
	// Keep valid high across back-to-back beats.
	task automatic send_beat(input logic op, input logic signed [TERM_W-1:0] val);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		error_value <= val;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and hold until every predicted drive beat has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Mix extremes, small values near zero and full-range noise.
	function automatic logic signed [TERM_W-1:0] pick_error();
		logic signed [TERM_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'sh7FFF_FFFF;
			1: v = 32'sh8000_0000;
			2, 3: begin
				v = $urandom_range(0, 2000);
				v = v - 1000;
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_gain();
		logic [15:0] g;
		case ($urandom_range(0, 7))
			0: g = 16'h7FFF;
			1: g = 16'h8000;
			2: g = 16'h0000;
			3, 4: g = 16'($urandom_range(0, 128)) - 16'd64;
			default: g = 16'($urandom());
		endcase
		return g;
	endfunction

	// Pick a fresh register set; the block must be idle when this runs.
	task automatic random_setup();
		logic [15:0] div_val, period_val;
		case ($urandom_range(0, 6))
			0: div_val = 16'd0;
			1: div_val = 16'd1;
			2: div_val = 16'd2;
			3: div_val = 16'hFFFF;
			4, 5: div_val = 16'($urandom_range(3, 300));
			default: div_val = 16'($urandom());
		endcase
		case ($urandom_range(0, 7))
			0: period_val = 16'd0;
			1: period_val = 16'd1;
			2: period_val = 16'hFFFF;
			3, 4, 5: period_val = 16'($urandom_range(2, 40));
			default: period_val = 16'($urandom());
		endcase
		apb_write(REG_GAIN_P, pick_gain());
		apb_write(REG_GAIN_I, pick_gain());
		apb_write(REG_GAIN_D, pick_gain());
		apb_write(REG_DIVISOR, div_val);
		apb_write(REG_PERIOD, period_val);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_UPDATE;
		error_value = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		gap_pct     = 0;
		stall_pct   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: zero gains, so drive stays zero.
		send_beat(OP_UPDATE, 32'sh7FFF_FFFF);
		send_beat(OP_UPDATE, 32'sh8000_0000);
		wait_for_results();

		// Extreme gains with a zero divisor (taken as one) and the longest period:
		// push the integral and derivative into saturation and the drive past range.
		apb_write(REG_GAIN_P, 16'h7FFF);
		apb_write(REG_GAIN_I, 16'h8000);
		apb_write(REG_GAIN_D, 16'h8000);
		apb_write(REG_DIVISOR, 16'd0);
		apb_write(REG_PERIOD, 16'hFFFF);
		send_beat(OP_UPDATE, 32'sh7FFF_FFFF);
		send_beat(OP_UPDATE, 32'sh7FFF_FFFF);
		send_beat(OP_UPDATE, 32'sh8000_0000);
		send_beat(OP_UPDATE, 32'sh8000_0000);
		send_beat(OP_UPDATE, 32'sd0);
		send_beat(OP_UPDATE, -32'sd1);
		send_beat(OP_UPDATE, 32'sd1);
		send_beat(OP_CLEAR, 32'sh1234_5678);   // payload ignored on a clear
		send_beat(OP_UPDATE, 32'sh5555_5555);
		send_beat(OP_UPDATE, 32'shAAAA_AAAA);
		wait_for_results();

		// Small gains, divisor two for half-way rounding, restart every third update.
		apb_write(REG_GAIN_P, 16'd3);
		apb_write(REG_GAIN_I, -16'sd2);
		apb_write(REG_GAIN_D, 16'd1);
		apb_write(REG_DIVISOR, 16'd2);
		apb_write(REG_PERIOD, 16'd3);
		send_beat(OP_UPDATE, 32'sd1);
		send_beat(OP_UPDATE, 32'sd2);
		send_beat(OP_UPDATE, 32'sd3);
		send_beat(OP_UPDATE, -32'sd3);
		send_beat(OP_UPDATE, -32'sd4);
		send_beat(OP_CLEAR, 32'sd0);
		send_beat(OP_UPDATE, 32'sd7);
		wait_for_results();

		// Zero period restarts on every update; largest divisor.
		apb_write(REG_DIVISOR, 16'hFFFF);
		apb_write(REG_PERIOD, 16'd0);
		apb_write(REG_GAIN_P, 16'h8000);
		send_beat(OP_UPDATE, 32'sd100);
		send_beat(OP_UPDATE, -32'sd100);
		send_beat(OP_CLEAR, 32'shFFFF_FFFF);
		wait_for_results();

		apb_write(REG_DIVISOR, 16'd1);
		apb_write(REG_PERIOD, 16'd1);
		send_beat(OP_UPDATE, 32'sd5);
		send_beat(OP_UPDATE, 32'sd5);
		wait_for_results();

		// Random phases: new registers each time, varied idling, none in the last.
		for (int ph = 0; ph < PHASES; ph++) begin
			random_setup();
			if (ph == PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 35;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// pause the sender until the pipe has emptied
				if ((ph == 0 && k == 100) || $urandom_range(0, 59) == 0)
					wait_for_results();
				if ($urandom_range(0, 9) == 0)
					send_beat(OP_CLEAR, $urandom());
				else
					send_beat(OP_UPDATE, pick_error());
			end
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("pid_with_periodic_restart_core test passed");
		else
			$display("pid_with_periodic_restart_core test failed");
		$finish;
	end

endmodule
